@@ rtl/core/bmn_pkg.sv @@
// Package for the block mean and norm normalizer.
// Default sizes and fixed-point constants shared by bmn_front, bmn_back and the top level.
package bmn_pkg;

    localparam int DEF_BLOCK_DEPTH = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int OUT_BITS        = 16;
    localparam int SCALE_SHIFT     = 16;
    localparam int QUOT_BITS       = 32;
    localparam int ROOT_STEPS      = 16;

endpackage

@@ rtl/core/bmn_front.sv @@
// Front part: item intake, running sums and the double-banked sample store.
// Depends on bmn_pkg for default sizes.
module bmn_front #(
    parameter int BLOCK_DEPTH = bmn_pkg::DEF_BLOCK_DEPTH,
    parameter int SAMPLE_BITS = bmn_pkg::DEF_SAMPLE_BITS,
    localparam int NB    = $clog2(BLOCK_DEPTH + 1),
    localparam int AW    = $clog2(BLOCK_DEPTH),
    localparam int SUM_W = SAMPLE_BITS + NB,
    localparam int SQ_W  = 2 * SAMPLE_BITS + NB,
    localparam int DW    = 1 + SQ_W + SUM_W + NB
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    output logic                   push,
    output logic [DW-1:0]          push_data,
    input  logic                   release_bank,
    input  logic [AW:0]            rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);
    logic [SAMPLE_BITS-1:0] mem [2 ** (AW + 1)];

    logic [NB-1:0]            fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic                     drop_reg, drop_next;
    logic                     bank_reg;
    logic [1:0]               used_reg, used_next;
    logic                     take, room;
    logic signed [SAMPLE_BITS-1:0]   x;
    logic signed [2*SAMPLE_BITS-1:0] xe, xx;

    assign x        = in_sample;
    assign xe       = (2 * SAMPLE_BITS)'(x);
    assign xx       = xe * xe;
    assign in_ready = (used_reg != 2'd2);
    assign take     = in_valid & in_ready;
    assign room     = fill_reg < NB'(BLOCK_DEPTH);
    assign push     = take & in_last;

    always_comb begin
        fill_next = room ? fill_reg + NB'(1) : fill_reg;
        sum_next  = room ? sum_reg + SUM_W'(x) : sum_reg;
        sq_next   = room ? sq_reg + SQ_W'($unsigned(xx)) : sq_reg;
        drop_next = drop_reg | ~room;
        push_data = {drop_next, sq_next, sum_next, fill_next};
        used_next = used_reg + {1'b0, push} - {1'b0, release_bank};
    end

    always_ff @(posedge aclk) begin
        if (take && room) begin
            mem[{bank_reg, fill_reg[AW-1:0]}] <= in_sample;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            drop_reg <= 1'b0;
            bank_reg <= 1'b0;
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
            if (take) begin
                if (in_last) begin
                    fill_reg <= '0;
                    sum_reg  <= '0;
                    sq_reg   <= '0;
                    drop_reg <= 1'b0;
                    bank_reg <= ~bank_reg;
                end else begin
                    fill_reg <= fill_next;
                    sum_reg  <= sum_next;
                    sq_reg   <= sq_next;
                    drop_reg <= drop_next;
                end
            end
        end
    end

endmodule

@@ rtl/core/bmn_queue.sv @@
// Two-entry queue of finished block descriptors between front and back.
// Self-contained; no package items needed.
module bmn_queue #(
    parameter int W = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head
);
    logic [W-1:0] d0_reg, d1_reg;
    logic [1:0]   count_reg, after_pop;

    assign not_empty = (count_reg != 2'd0);
    assign head      = d0_reg;
    assign after_pop = count_reg - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (push && (after_pop == 2'd0)) begin
            d0_reg <= push_data;
        end else if (pop) begin
            d0_reg <= d1_reg;
        end
        if (push && (after_pop != 2'd0)) begin
            d1_reg <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= after_pop + {1'b0, push};
        end
    end

endmodule

@@ rtl/core/bmn_back.sv @@
// Back part: block statistics, per-sample divide and root, result register.
// Depends on bmn_pkg for sizes and fixed-point constants.
module bmn_back #(
    parameter int BLOCK_DEPTH = bmn_pkg::DEF_BLOCK_DEPTH,
    parameter int SAMPLE_BITS = bmn_pkg::DEF_SAMPLE_BITS,
    localparam int NB    = $clog2(BLOCK_DEPTH + 1),
    localparam int AW    = $clog2(BLOCK_DEPTH),
    localparam int SUM_W = SAMPLE_BITS + NB,
    localparam int SQ_W  = 2 * SAMPLE_BITS + NB,
    localparam int DW    = 1 + SQ_W + SUM_W + NB
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        desc_valid,
    input  logic [DW-1:0]               desc_data,
    output logic                        desc_pop,
    output logic                        release_bank,
    output logic [AW:0]                 rd_addr,
    input  logic [SAMPLE_BITS-1:0]      rd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bmn_pkg::OUT_BITS-1:0] out_data,
    output logic                        out_last,
    output logic                        out_flag
);
    import bmn_pkg::*;

    localparam int Q_W  = 2 * SUM_W;
    localparam int NQ_W = Q_W + NB;
    localparam int DM_W = SAMPLE_BITS + NB;
    localparam int D_W  = DM_W + 1;
    localparam int R_W  = 2 * DM_W + 2 * SCALE_SHIFT;
    localparam int CW   = NQ_W + QUOT_BITS;
    localparam int SW   = $clog2(QUOT_BITS);

    typedef enum logic [10:0] {
        B_IDLE   = 11'b00000000001,
        B_PREP   = 11'b00000000010,
        B_NORM   = 11'b00000000100,
        B_SCALE  = 11'b00000001000,
        B_LOAD   = 11'b00000010000,
        B_DIFF   = 11'b00000100000,
        B_SQUARE = 11'b00001000000,
        B_SAT    = 11'b00010000000,
        B_DIV    = 11'b00100000000,
        B_ROOT   = 11'b01000000000,
        B_EMIT   = 11'b10000000000
    } state_t;

    state_t                  state_reg;
    logic [NB-1:0]           n_reg, idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    drop_reg, bank_reg;
    logic [NB+SQ_W-1:0]      p1_reg;
    logic [Q_W-1:0]          s2_reg, q_reg;
    logic [NQ_W-1:0]         nq_reg;
    logic                    qzero_reg;
    logic signed [D_W-1:0]   d_reg;
    logic [R_W-1:0]          r_reg;
    logic                    dneg_reg, dzero_reg;
    logic [CW-1:0]           rem_reg, dv_reg;
    logic [QUOT_BITS-1:0]    op_reg, res_reg, one_reg;
    logic [SW-1:0]           step_reg;
    logic                    out_valid_reg, out_last_reg, out_flag_reg;
    logic [OUT_BITS-1:0]     out_data_reg;

    logic [SUM_W-1:0]        sum_mag;
    logic signed [D_W-1:0]   nx, x_ext;
    logic [DM_W-1:0]         d_mag;
    logic [2*DM_W-1:0]       d_sq;
    logic                    div_hit;
    logic [QUOT_BITS-1:0]    quot_next, root_try;
    logic [OUT_BITS:0]       y;
    logic [OUT_BITS-1:0]     result;
    logic                    can_emit, is_last;

    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign x_ext     = D_W'($signed(rd_data));
    assign nx        = D_W'($signed({1'b0, n_reg})) * x_ext;
    assign d_mag     = d_reg[D_W-1] ? DM_W'(-d_reg) : DM_W'(d_reg);
    assign d_sq      = (2 * DM_W)'(d_mag) * (2 * DM_W)'(d_mag);
    assign div_hit   = rem_reg >= dv_reg;
    assign quot_next = {op_reg[QUOT_BITS-2:0], div_hit};
    assign root_try  = res_reg + one_reg;
    assign y         = (res_reg[OUT_BITS:0] + (OUT_BITS + 1)'(1)) >> 1;
    assign can_emit  = ~out_valid_reg | out_ready;
    assign is_last   = (idx_reg + NB'(1)) == n_reg;

    always_comb begin
        if (qzero_reg || dzero_reg) begin
            result = '0;
        end else if (dneg_reg) begin
            result = OUT_BITS'((OUT_BITS + 1)'(0) - y);
        end else if (y[OUT_BITS] || y[OUT_BITS-1]) begin
            result = {1'b0, {(OUT_BITS - 1){1'b1}}};
        end else begin
            result = y[OUT_BITS-1:0];
        end
    end

    assign desc_pop     = (state_reg == B_IDLE) && desc_valid;
    assign release_bank = (state_reg == B_EMIT) && can_emit && is_last;
    assign rd_addr      = {bank_reg, idx_reg[AW-1:0]};
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_last     = out_last_reg;
    assign out_flag     = out_flag_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                {drop_reg, sq_reg, sum_reg, n_reg} <= desc_data;
            end
            B_PREP: begin
                p1_reg <= (NB + SQ_W)'(n_reg) * (NB + SQ_W)'(sq_reg);
                s2_reg <= Q_W'(sum_mag) * Q_W'(sum_mag);
            end
            B_NORM: begin
                q_reg <= Q_W'(p1_reg) - s2_reg;
            end
            B_SCALE: begin
                nq_reg    <= NQ_W'(n_reg) * NQ_W'(q_reg);
                qzero_reg <= (q_reg == '0);
                idx_reg   <= '0;
            end
            B_DIFF: begin
                d_reg <= nx - D_W'(sum_reg);
            end
            B_SQUARE: begin
                r_reg     <= {d_sq, {(2 * SCALE_SHIFT){1'b0}}};
                dneg_reg  <= d_reg[D_W-1];
                dzero_reg <= (d_reg == '0);
            end
            B_SAT: begin
                rem_reg <= CW'(r_reg);
                dv_reg  <= CW'(nq_reg) << (QUOT_BITS - 1);
                res_reg <= '0;
                one_reg <= QUOT_BITS'(1) << (QUOT_BITS - 2);
                if (CW'(r_reg) >= (CW'(nq_reg) << QUOT_BITS)) begin
                    op_reg   <= '1;
                    step_reg <= SW'(ROOT_STEPS - 1);
                end else begin
                    op_reg   <= '0;
                    step_reg <= SW'(QUOT_BITS - 1);
                end
            end
            B_DIV: begin
                if (div_hit) begin
                    rem_reg <= rem_reg - dv_reg;
                end
                dv_reg <= dv_reg >> 1;
                op_reg <= quot_next;
                if (step_reg == '0) begin
                    step_reg <= SW'(ROOT_STEPS - 1);
                end else begin
                    step_reg <= step_reg - SW'(1);
                end
            end
            B_ROOT: begin
                if (op_reg >= root_try) begin
                    op_reg  <= op_reg - root_try;
                    res_reg <= (res_reg >> 1) + one_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                one_reg  <= one_reg >> 2;
                step_reg <= step_reg - SW'(1);
            end
            B_EMIT: begin
                if (can_emit) begin
                    out_data_reg <= result;
                    out_last_reg <= is_last;
                    out_flag_reg <= drop_reg;
                    idx_reg      <= idx_reg + NB'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= (out_valid_reg & ~out_ready)
                           | ((state_reg == B_EMIT) & can_emit);
            case (state_reg)
                B_IDLE: begin
                    if (desc_valid) begin
                        state_reg <= B_PREP;
                    end
                end
                B_PREP:   state_reg <= B_NORM;
                B_NORM:   state_reg <= B_SCALE;
                B_SCALE:  state_reg <= B_LOAD;
                B_LOAD:   state_reg <= B_DIFF;
                B_DIFF:   state_reg <= B_SQUARE;
                B_SQUARE: state_reg <= B_SAT;
                B_SAT: begin
                    if (CW'(r_reg) >= (CW'(nq_reg) << QUOT_BITS)) begin
                        state_reg <= B_ROOT;
                    end else begin
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= B_ROOT;
                    end
                end
                B_ROOT: begin
                    if (step_reg == '0) begin
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (can_emit) begin
                        if (is_last) begin
                            state_reg <= B_IDLE;
                            bank_reg  <= ~bank_reg;
                        end else begin
                            state_reg <= B_LOAD;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/block_mean_norm_normalizer.sv @@
// Top level of the block mean and norm normalizer.
// Instantiates bmn_front, bmn_queue and bmn_back; depends on bmn_pkg.
//
// Samples of one block enter one item per clock, with s_tlast on the last
// sample of the block; samples beyond BLOCK_DEPTH are dropped and the block's
// results carry m_tuser high. Two store banks let the next block load while
// the previous one is emitted; input stalls only when both banks hold
// finished blocks. Each block first passes prepare, norm and scale; then each
// result passes load, difference, square, a saturation check, 32 steps of
// the serial divider when the quotient fits, 16 of the serial square root
// and output, skipping the divider when the scaled quotient saturates.
// Results leave in arrival order, m_tlast on the last one of the block.
module block_mean_norm_normalizer #(
    parameter int BLOCK_DEPTH = bmn_pkg::DEF_BLOCK_DEPTH,
    parameter int SAMPLE_BITS = bmn_pkg::DEF_SAMPLE_BITS,
    localparam int IN_W = ((SAMPLE_BITS > 16 ? SAMPLE_BITS : 16) + 7) / 8 * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_W-1:0]              s_tdata,   // sample
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bmn_pkg::OUT_BITS-1:0] m_tdata,   // normalized
    output logic                         m_tlast,
    output logic                         m_tuser    // overflowed
);
    import bmn_pkg::*;

    localparam int NB    = $clog2(BLOCK_DEPTH + 1);
    localparam int AW    = $clog2(BLOCK_DEPTH);
    localparam int SUM_W = SAMPLE_BITS + NB;
    localparam int SQ_W  = 2 * SAMPLE_BITS + NB;
    localparam int DW    = 1 + SQ_W + SUM_W + NB;

    logic                   push, pop, not_empty, release_bank;
    logic [DW-1:0]          push_data, head;
    logic [AW:0]            rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    bmn_front #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_sample    (s_tdata[SAMPLE_BITS-1:0]),
        .in_last      (s_tlast),
        .push         (push),
        .push_data    (push_data),
        .release_bank (release_bank),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    bmn_queue #(
        .W (DW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    bmn_back #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .desc_valid   (not_empty),
        .desc_data    (head),
        .desc_pop     (pop),
        .release_bank (release_bank),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata),
        .out_last     (m_tlast),
        .out_flag     (m_tuser)
    );

endmodule

@@ dv/bmn_checker.sv @@
// Checker for the block mean and norm normalizer: watches both item channels,
// predicts each block's normalized results and compares them in order.
// Depends on bmn_pkg for the result width.
`timescale 1ns / 100ps

module bmn_checker #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [15:0]                  s_tdata,
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [bmn_pkg::OUT_BITS-1:0] m_tdata,
    input  logic                         m_tlast,
    input  logic                         m_tuser,
    output int                           fail_count,
    output int                           pending_count,
    output int                           result_count,
    output int                           overflow_blocks
);

    typedef struct packed {
        logic signed [15:0] normalized;
        logic               final_of_block;
        logic               overflowed;
    } norm_result_t;

    norm_result_t      norm_q[$];
    logic signed [15:0] held[BLOCK_DEPTH];
    int                fill;
    longint            sum_acc;
    longint            sq_acc;
    logic              dropped;

    // largest y in [0,32768] with (2y-1)^2 * nq <= (65536*ad)^2
    function automatic int scaled_mag(logic [127:0] nq, logic [127:0] ad);
        logic [127:0] rhs;
        logic [127:0] t;
        int lo;
        int hi;
        int mid;
        rhs = (ad << 16) * (ad << 16);
        lo  = 0;
        hi  = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            if (nq * t * t <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic close_block();
        longint q;
        longint d;
        int     m;
        norm_result_t r;
        q = fill * sq_acc - sum_acc * sum_acc;
        for (int i = 0; i < fill; i++) begin
            d = longint'(fill) * longint'(held[i]) - sum_acc;
            r.normalized = '0;
            if (q != 0 && d != 0) begin
                m = scaled_mag(128'(fill) * 128'(q), 128'(d < 0 ? -d : d));
                if (d > 0) r.normalized = (m > 32767) ? 16'sd32767 : 16'(m);
                else r.normalized = 16'(-m);
            end
            r.final_of_block = (i + 1 == fill);
            r.overflowed     = dropped;
            norm_q.push_back(r);
        end
        if (dropped) overflow_blocks++;
        fill    = 0;
        sum_acc = 0;
        sq_acc  = 0;
        dropped = 1'b0;
    endtask

    initial begin
        fail_count      = 0;
        pending_count   = 0;
        result_count    = 0;
        overflow_blocks = 0;
        fill            = 0;
        sum_acc         = 0;
        sq_acc          = 0;
        dropped         = 1'b0;
    end

    always @(posedge aclk) begin
        norm_result_t e;
        logic signed [15:0] x;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (norm_q.size() == 0) begin
                    $error("unexpected result item: normalized=%0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    e = norm_q.pop_front();
                    if (m_tdata !== e.normalized) begin
                        $error("normalized: expected %0d, got %0d",
                               e.normalized, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== e.final_of_block) begin
                        $error("final_of_block: expected %0b, got %0b",
                               e.final_of_block, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== e.overflowed) begin
                        $error("overflowed: expected %0b, got %0b", e.overflowed, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                x = s_tdata;
                if (fill < BLOCK_DEPTH) begin
                    held[fill] = x;
                    fill++;
                    sum_acc += x;
                    sq_acc  += longint'(x) * longint'(x);
                end else begin
                    dropped = 1'b1;
                end
                if (s_tlast) close_block();
            end
            pending_count = norm_q.size();
        end
    end

endmodule

@@ dv/tb_block_mean_norm_normalizer.sv @@
// Top of the normalizer testbench: drives sample blocks with random gaps and
// back-pressure and gives the verdict. Depends on bmn_checker and the RTL.
`timescale 1ns / 100ps

module tb_block_mean_norm_normalizer;

    localparam int LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // normalized
    logic        m_tlast;
    logic        m_tuser;   // overflowed
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          overflow_blocks;
    int          cycle_count = 0;
    int          items_sent;
    int          blocks_sent;
    logic        calm;

    block_mean_norm_normalizer i_dut (.*);

    bmn_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // back-pressure in bursts
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 17);
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic push_sample(logic [15:0] v, logic last);
        int gap;
        if (!calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (last) blocks_sent++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40)) - 16'd20;
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 2000)) - 16'd1000;
        endcase
    endfunction

    task automatic push_block(int len, logic flat);
        logic [15:0] v;
        v = rand_sample();
        for (int i = 0; i < len; i++)
            push_sample(flat ? v : rand_sample(), i == len - 1);
    endtask

    initial begin
        int len;
        items_sent  = 0;
        blocks_sent = 0;
        calm        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        push_sample(16'h7fff, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b1);
        push_sample(16'd5, 1'b0);
        push_sample(16'd5, 1'b0);
        push_sample(16'd5, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hffff, 1'b1);
        push_sample(16'd100, 1'b0);
        push_sample(16'hfff9, 1'b0);
        push_sample(16'd3000, 1'b0);
        push_sample(16'hb1e0, 1'b1);
        push_sample(16'h5555, 1'b0);
        push_sample(16'haaaa, 1'b1);

        push_block(67, 1'b0);
        while (items_sent < 95) begin
            len = $urandom_range(0, 5) == 0 ? $urandom_range(13, 30) : $urandom_range(1, 12);
            push_block(len, $urandom_range(0, 9) == 0);
        end
        calm = 1'b1;
        push_block(64, 1'b0);
        push_block(6, 1'b0);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d samples in %0d blocks, %0d with dropped samples;",
                 items_sent, blocks_sent, overflow_blocks);
        $display("checked %0d normalized results with random gaps and stalls.", result_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
